// File: hdl/bre_pkg.sv
// Shared constants, types and helpers for the binary range encoder.
package bre_pkg;

    localparam int PROB_BITS      = 15;
    localparam int PENDING_BITS   = 32;
    localparam int TOP_BYTE_POS   = 16;
    localparam int BYTE_BITS      = 8;
    localparam int RANGE_BITS     = TOP_BYTE_POS + BYTE_BITS;
    localparam int LOW_BITS       = RANGE_BITS + 1;
    localparam int REL_BITS       = BYTE_BITS + 1;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic [RANGE_BITS-1:0] RENORM_LIMIT =
        RANGE_BITS'((32'hFF << (TOP_BYTE_POS - 8)) + 1);
    localparam logic [RANGE_BITS-1:0] RANGE_RESET =
        RANGE_BITS'(32'hFF << TOP_BYTE_POS);
    localparam logic [RANGE_BITS-1:0] RANGE_FLUSH_MIN =
        RANGE_BITS'(32'h1 << TOP_BYTE_POS);

    localparam logic [BYTE_BITS-1:0]    BYTE_FF     = '1;
    localparam logic [BYTE_BITS-1:0]    BYTE_00     = '0;
    localparam logic [BYTE_BITS-1:0]    HELD_RESET  = BYTE_FF;
    localparam logic [REL_BITS-1:0]     REL_FF      = {1'b0, BYTE_FF};
    localparam logic [PENDING_BITS-1:0] PENDING_MAX = '1;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_FLUSH  = 1'b1
    } t_mode;

    // One queue entry: up to two released values, plus a closing step on flush.
    typedef struct packed {
        logic [1:0]          cnt;
        logic                flush;
        logic [REL_BITS-1:0] v0;
        logic [REL_BITS-1:0] v1;
    } t_rel_entry;

    // All bits at and below the leading one set.
    function automatic logic [RANGE_BITS-1:0] smear(input logic [RANGE_BITS-1:0] x);
        logic [RANGE_BITS-1:0] y;
        y = x;
        y = y | (y >> 1);
        y = y | (y >> 2);
        y = y | (y >> 4);
        y = y | (y >> 8);
        y = y | (y >> 16);
        return y;
    endfunction

endpackage

// File: hdl/bre_front.sv
// Front end: interval split, renormalisation and flush rounding.
module bre_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic [bre_pkg::PROB_BITS-1:0]    i_prob,
    input  logic                             i_bit,
    input  logic                             i_full,
    output logic                             o_push,
    output bre_pkg::t_rel_entry              o_entry
);
    import bre_pkg::*;

    localparam int PROD_BITS = RANGE_BITS + PROB_BITS;

    logic [LOW_BITS-1:0]   r_low,   n_low;
    logic [RANGE_BITS-1:0] r_range, n_range;

    logic                  w_accept, w_flush;
    logic [PROB_BITS-1:0]  w_prob;
    logic [PROD_BITS-1:0]  w_prod;
    logic [RANGE_BITS-1:0] w_r0;
    logic [LOW_BITS-1:0]   w_low1, w_low2, w_low3;
    logic [RANGE_BITS-1:0] w_range1, w_range2, w_range3;
    logic                  w_s1, w_s2;
    logic                  w_fs;
    logic [LOW_BITS-1:0]   w_lowf;
    logic [RANGE_BITS-1:0] w_rangef, w_mask;
    logic [LOW_BITS:0]     w_sum, w_val;
    logic [REL_BITS-1:0]   w_frel;

    assign w_accept = i_valid && !i_full;
    assign o_ready  = !i_full;
    assign w_flush  = (t_mode'(i_mode) == MODE_FLUSH);

    // split
    assign w_prob = (i_prob == '0) ? PROB_BITS'(1) : i_prob;
    assign w_prod = PROD_BITS'(r_range) * PROD_BITS'(w_prob);
    assign w_r0   = w_prod[PROD_BITS-1:PROB_BITS];

    always_comb begin
        if (i_bit) begin
            w_low1   = r_low + LOW_BITS'(w_r0);
            w_range1 = r_range - w_r0;
        end else begin
            w_low1   = r_low;
            w_range1 = w_r0;
        end
    end

    // two unrolled renormalisation steps
    assign w_s1     = (w_range1 < RENORM_LIMIT);
    assign w_low2   = w_s1 ? LOW_BITS'({w_low1[TOP_BYTE_POS-1:0], BYTE_00}) : w_low1;
    assign w_range2 = w_s1 ? {w_range1[TOP_BYTE_POS-1:0], BYTE_00} : w_range1;
    assign w_s2     = w_s1 && (w_range2 < RENORM_LIMIT);
    assign w_low3   = w_s2 ? LOW_BITS'({w_low2[TOP_BYTE_POS-1:0], BYTE_00}) : w_low2;
    assign w_range3 = w_s2 ? {w_range2[TOP_BYTE_POS-1:0], BYTE_00} : w_range2;

    // flush: optional shift, then round low up to the shortest tail
    assign w_fs     = (r_range < RANGE_FLUSH_MIN);
    assign w_lowf   = w_fs ? LOW_BITS'({r_low[TOP_BYTE_POS-1:0], BYTE_00}) : r_low;
    assign w_rangef = w_fs ? {r_range[TOP_BYTE_POS-1:0], BYTE_00} : r_range;
    assign w_mask   = smear(w_rangef) >> 1;
    assign w_sum    = {1'b0, w_lowf} + (LOW_BITS+1)'(w_mask) + (LOW_BITS+1)'(1);

    always_comb begin
        if ((w_lowf & LOW_BITS'(w_mask)) != '0) begin
            w_val = w_sum & ~((LOW_BITS+1)'(w_mask));
        end else begin
            w_val = {1'b0, w_lowf};
        end
    end

    assign w_frel = w_val[LOW_BITS-1:TOP_BYTE_POS];

    always_comb begin
        o_entry = '0;
        if (w_flush) begin
            o_entry.flush = 1'b1;
            if (w_fs) begin
                o_entry.cnt = 2'd2;
                o_entry.v0  = r_low[LOW_BITS-1:TOP_BYTE_POS];
                o_entry.v1  = w_frel;
            end else begin
                o_entry.cnt = 2'd1;
                o_entry.v0  = w_frel;
            end
        end else begin
            o_entry.cnt = w_s2 ? 2'd2 : (w_s1 ? 2'd1 : 2'd0);
            o_entry.v0  = w_low1[LOW_BITS-1:TOP_BYTE_POS];
            o_entry.v1  = w_low2[LOW_BITS-1:TOP_BYTE_POS];
        end
    end

    assign o_push = w_accept && (w_flush || w_s1);

    always_comb begin
        n_low   = r_low;
        n_range = r_range;
        if (w_accept) begin
            if (w_flush) begin
                n_low   = '0;
                n_range = RANGE_RESET;
            end else begin
                n_low   = w_low3;
                n_range = w_range3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_range <= RANGE_RESET;
        end else begin
            r_low   <= n_low;
            r_range <= n_range;
        end
    end

endmodule

// File: hdl/bre_queue.sv
// Short register queue between front and back end.
module bre_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bre_pkg::t_rel_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output bre_pkg::t_rel_entry o_head
);
    import bre_pkg::*;

    t_rel_entry           r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QPTR_BITS:0]   r_count, n_count;

    assign o_full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + QPTR_BITS'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + QPTR_BITS'(1) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_BITS+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");

endmodule

// File: hdl/bre_back.sv
// Back end: held byte and 0xFF run tracking, carry resolution, output register.
module bre_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  bre_pkg::t_rel_entry                i_entry,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [bre_pkg::BYTE_BITS-1:0]      o_lead,
    output logic [bre_pkg::BYTE_BITS-1:0]      o_fill,
    output logic [bre_pkg::PENDING_BITS-1:0]   o_count,
    output logic                               o_last
);
    import bre_pkg::*;

    logic [1:0]              r_step, n_step;
    logic [BYTE_BITS-1:0]    r_held, n_held;
    logic [PENDING_BITS-1:0] r_pending, n_pending;
    logic                    r_out_valid, n_out_valid;
    logic [BYTE_BITS-1:0]    r_lead, r_fill;
    logic [PENDING_BITS-1:0] r_count;
    logic                    r_last;

    logic                    w_advance, w_final, w_emit, w_carry;
    logic [1:0]              w_last_step;
    logic [REL_BITS-1:0]     w_v;

    assign w_last_step = i_entry.flush ? i_entry.cnt : i_entry.cnt - 2'd1;
    assign w_final     = i_entry.flush && (r_step == i_entry.cnt);
    assign w_v         = w_final ? '0 : ((r_step == 2'd0) ? i_entry.v0 : i_entry.v1);
    assign w_carry     = w_v[REL_BITS-1];
    assign w_advance   = i_valid && (!r_out_valid || i_ready);
    assign w_emit      = (w_v != REL_FF) && (r_pending != '0);
    assign o_pop       = w_advance && (r_step == w_last_step);

    always_comb begin
        n_step    = r_step;
        n_held    = r_held;
        n_pending = r_pending;
        if (w_advance) begin
            n_step = (r_step == w_last_step) ? 2'd0 : r_step + 2'd1;
            if (w_final) begin
                n_held    = HELD_RESET;
                n_pending = '0;
            end else if (w_v == REL_FF) begin
                if (r_pending != PENDING_MAX) begin
                    n_pending = r_pending + PENDING_BITS'(1);
                end
            end else begin
                n_held    = w_v[BYTE_BITS-1:0];
                n_pending = PENDING_BITS'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance && w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_held      <= HELD_RESET;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_held      <= n_held;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_lead  <= r_held + BYTE_BITS'(w_carry);
            r_fill  <= w_carry ? BYTE_00 : BYTE_FF;
            r_count <= r_pending - PENDING_BITS'(1);
            r_last  <= w_final;
        end
    end

    assign o_valid = r_out_valid;
    assign o_lead  = r_lead;
    assign o_fill  = r_fill;
    assign o_count = r_count;
    assign o_last  = r_last;

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_final) |=> (r_pending == '0 && r_held == HELD_RESET))
        else $error("flush did not return held byte and run count to reset");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (r_step <= w_last_step))
        else $error("step index beyond the entry");

endmodule

// File: hdl/binary_range_encoder.sv
// Top level of the binary range encoder: front end, release queue and back end.
//
// Binary range encoder with carry propagation. Each input transaction either
// encodes one bit against its 15-bit zero probability or, with tuser set,
// flushes the coder. Output transactions each describe a byte release: a lead
// byte (held byte plus carry) followed by fill_count copies of the fill byte
// (0xFF without carry, 0x00 with carry); tlast marks the final transaction of
// a flush, after which the coder is back at its reset values. An encoded bit
// produces zero to two output transactions, a flush one to three. The input
// takes one transaction per cycle: the front end's range loop (one 24x15
// multiply, add/subtract and two unrolled renormalisation steps on the range
// register) is combinational. Released byte values wait in a
// four-entry queue; the back end retires one released value per cycle (a
// flush adds one closing step), so the input stalls only when bytes are
// released faster than that or the output side holds off tready. Results sit
// in an output register, so a new input is taken while a result waits.
module binary_range_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [14:0] prob_zero, [15] bit_value
    input  logic [0:0]  i_s_axis_tuser,   // [0] mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] lead_byte, [15:8] fill_byte,
                                          // [47:16] fill_count
    output logic        o_m_axis_tlast    // last
);
    import bre_pkg::*;

    logic       w_push, w_full, w_pop, w_q_valid;
    t_rel_entry w_push_entry, w_head;

    logic [BYTE_BITS-1:0]    w_lead, w_fill;
    logic [PENDING_BITS-1:0] w_count;

    // front: split and renormalise, queue the released values
    bre_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_mode  (i_s_axis_tuser[0]),
        .i_prob  (i_s_axis_tdata[PROB_BITS-1:0]),
        .i_bit   (i_s_axis_tdata[PROB_BITS]),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    bre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // back: resolve carries against the held byte and the 0xFF run
    bre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_entry (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_lead  (w_lead),
        .o_fill  (w_fill),
        .o_count (w_count),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_count, w_fill, w_lead};

endmodule

// File: verif/binary_range_encoder_tb.sv
// Self-checking testbench for the binary range encoder: directed and random bit streams.
//
// Every input transaction is fed to a behavioural coder kept here (low, range,
// held byte and pending run) at the moment the DUT accepts it. The byte runs
// that the coder works out are queued in order of arrival. Each output
// transaction is compared field by field against the oldest queued run.
// Streams are mostly well formed: a run of encoded bits closed by a flush.
// The sender idles in bursts and the receiver stalls on a word-based pattern.
module binary_range_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bre_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [PROB_BITS-1:0] PROB_TOP = '1;

    // One input transaction; drain_first holds it back until no result is owed
    typedef struct {
        t_mode                mode;
        logic [PROB_BITS-1:0] prob_zero;
        logic                 bit_value;
        logic                 drain_first;
    } t_bit_item;

    // One byte run: lead byte, then fill_count copies of the fill byte
    typedef struct {
        logic [BYTE_BITS-1:0]    lead_byte;
        logic [BYTE_BITS-1:0]    fill_byte;
        logic [PENDING_BITS-1:0] fill_count;
        logic                    last;
    } t_byte_run;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_tdata = '0;    // [14:0] prob_zero, [15] bit_value
    logic [0:0]  s_tuser = '0;    // [0] mode
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_tdata;         // [7:0] lead_byte, [15:8] fill_byte, [47:16] fill_count
    logic        m_tlast;         // last

    t_bit_item   bit_items[$];      // stimulus not yet presented
    t_byte_run   expected_runs[$];  // runs owed by the DUT, oldest first
    t_bit_item   in_flight;         // transaction currently on the slave side

    // Behavioural coder state
    logic [LOW_BITS-1:0]     enc_low;
    logic [RANGE_BITS-1:0]   enc_range;
    logic [BYTE_BITS-1:0]    enc_held;
    logic [PENDING_BITS-1:0] enc_pending;

    int          n_fail      = 0;
    int          cycle_count = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    logic [15:0] stall_word  = '1;
    logic [3:0]  stall_pos   = '0;

    binary_range_encoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioural coder
    // ------------------------------------------------------------------
    task automatic reset_coder();
        enc_low     = '0;
        enc_range   = RANGE_RESET;
        enc_held    = HELD_RESET;
        enc_pending = '0;
    endtask

    // A released 9-bit value: 0xFF only lengthens the pending run, anything
    // else settles the held byte and its run (carry in bit 8) and is held next.
    task automatic release_byte(input logic [REL_BITS-1:0] v);
        t_byte_run run;
        if (v == REL_FF) begin
            if (enc_pending != PENDING_MAX) enc_pending++;
        end else begin
            if (enc_pending != '0) begin
                run.lead_byte  = enc_held + BYTE_BITS'(v[REL_BITS-1]);
                run.fill_byte  = v[REL_BITS-1] ? BYTE_00 : BYTE_FF;
                run.fill_count = enc_pending - PENDING_BITS'(1);
                run.last       = 1'b0;
                expected_runs.push_back(run);
            end
            enc_pending = PENDING_BITS'(1);
            enc_held    = v[BYTE_BITS-1:0];
        end
    endtask

    task automatic shift_byte_out();
        release_byte(enc_low[LOW_BITS-1:TOP_BYTE_POS]);
        enc_low   = LOW_BITS'({enc_low[TOP_BYTE_POS-1:0], BYTE_00});
        enc_range = {enc_range[RANGE_BITS-BYTE_BITS-1:0], BYTE_00};
    endtask

    // Works out the byte runs that one accepted transaction causes
    task automatic compute_byte_runs(input t_bit_item item);
        logic [PROB_BITS-1:0]            p;
        logic [RANGE_BITS+PROB_BITS-1:0] prod;
        logic [RANGE_BITS-1:0]           split;
        logic [31:0]                     rounded;
        logic [31:0]                     step;
        int                              top;
        int                              first_new;
        t_byte_run                       run;
        first_new = expected_runs.size();
        if (item.mode == MODE_ENCODE) begin
            // zero probability is clamped so neither part of the split is empty
            p     = (item.prob_zero == '0) ? PROB_BITS'(1) : item.prob_zero;
            prod  = enc_range * p;
            split = prod[RANGE_BITS+PROB_BITS-1:PROB_BITS];
            if (!item.bit_value) begin
                enc_range = split;
            end else begin
                enc_low   = enc_low + split;   // wraps at 25 bits
                enc_range = enc_range - split;
            end
            repeat (2) begin
                if (enc_range < RENORM_LIMIT) shift_byte_out();
            end
        end else begin
            if (enc_range < RANGE_FLUSH_MIN) shift_byte_out();
            // shortest tail: round low up to a multiple of the largest power of two inside range
            top = 0;
            while (top < RANGE_BITS - 1 && (32'd1 << (top + 1)) <= enc_range) top++;
            step    = 32'd1 << top;
            rounded = 32'(enc_low);
            if ((rounded & (step - 1)) != 0) rounded = (rounded + step) & ~(step - 1);
            release_byte(rounded[TOP_BYTE_POS +: REL_BITS]);
            if (enc_pending != '0) release_byte('0);
            if (expected_runs.size() > first_new) begin
                run      = expected_runs.pop_back();
                run.last = 1'b1;
                expected_runs.push_back(run);
            end
            reset_coder();
        end
    endtask

    function automatic void add_item(input t_mode mode, input logic [PROB_BITS-1:0] prob,
                                     input logic bit_value, input logic drain_first);
        t_bit_item item;
        item.mode        = mode;
        item.prob_zero   = prob;
        item.bit_value   = bit_value;
        item.drain_first = drain_first;
        bit_items.push_back(item);
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps; a presented
    // transaction stays put until it is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic taken;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            taken = s_valid && s_ready;
            if (taken) compute_byte_runs(in_flight);
            if (!s_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (bit_items.size() != 0 &&
                             (!bit_items[0].drain_first || expected_runs.size() == 0)) begin
                    in_flight = bit_items.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= {in_flight.bit_value, in_flight.prob_zero};
                    s_tuser <= in_flight.mode;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // about a third of bursts run straight on with no gap
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: a fresh 16-bit ready word each time the
    // last one is used up, either solid, random or sparse.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_pos == '0) begin
                case ($urandom_range(0, 3))
                    0, 1:    stall_word = '1;
                    2:       stall_word = 16'($urandom);
                    default: stall_word = 16'($urandom & $urandom);
                endcase
            end
            m_ready <= stall_word[stall_pos];
            stall_pos = stall_pos + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every output transaction against the oldest expected run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_byte_run want;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_runs.size() == 0) begin
                $error("unexpected transaction: lead_byte %02h fill_byte %02h fill_count %0d",
                       m_tdata[7:0], m_tdata[15:8], m_tdata[47:16]);
                n_fail++;
            end else begin
                want = expected_runs.pop_front();
                if (m_tdata[7:0] !== want.lead_byte) begin
                    $error("lead_byte: expected %02h, actual %02h", want.lead_byte, m_tdata[7:0]);
                    n_fail++;
                end
                if (m_tdata[15:8] !== want.fill_byte) begin
                    $error("fill_byte: expected %02h, actual %02h", want.fill_byte, m_tdata[15:8]);
                    n_fail++;
                end
                if (m_tdata[47:16] !== want.fill_count) begin
                    $error("fill_count: expected %0d, actual %0d",
                           want.fill_count, m_tdata[47:16]);
                    n_fail++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout: %0d items unsent, %0d runs outstanding",
                   bit_items.size(), expected_runs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial begin
        int                   made;
        int                   profile;
        int                   stream_len;
        logic [PROB_BITS-1:0] p;
        logic [PROB_BITS-1:0] fixed_p;
        logic                 b;

        reset_coder();

        // Flush of an empty stream, straight after reset
        add_item(MODE_FLUSH, '0, 1'b0, 1'b0);
        // Probability extremes, zero probability clamped, both bit values
        add_item(MODE_ENCODE, '0, 1'b0, 1'b0);
        add_item(MODE_ENCODE, '0, 1'b1, 1'b0);
        add_item(MODE_ENCODE, PROB_TOP, 1'b0, 1'b0);
        add_item(MODE_ENCODE, PROB_TOP, 1'b1, 1'b0);
        add_item(MODE_ENCODE, 15'd1, 1'b0, 1'b0);
        add_item(MODE_ENCODE, 15'd1, 1'b1, 1'b0);
        add_item(MODE_ENCODE, 15'h4000, 1'b0, 1'b0);
        add_item(MODE_ENCODE, 15'h4000, 1'b1, 1'b0);
        // flush with every other bit set: those must be ignored
        add_item(MODE_FLUSH, PROB_TOP, 1'b1, 1'b0);
        // Unlikely ones at top probability: low climbs into runs of 0xFF
        repeat (6) add_item(MODE_ENCODE, PROB_TOP, 1'b1, 1'b0);
        add_item(MODE_FLUSH, '0, 1'b0, 1'b0);
        // Tiny range: double renormalisation per bit
        repeat (3) add_item(MODE_ENCODE, 15'd1, 1'b0, 1'b0);
        add_item(MODE_FLUSH, '0, 1'b0, 1'b0);
        // Back-to-back flushes
        add_item(MODE_FLUSH, '0, 1'b0, 1'b0);

        // Random streams, each closed by a flush
        made = 0;
        while (made < RANDOM_ITEMS) begin
            profile    = $urandom_range(0, 3);
            stream_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(4, 60);
            // keep room for the closing flush within the item budget
            if (stream_len > RANDOM_ITEMS - made - 1) stream_len = RANDOM_ITEMS - made - 1;
            fixed_p    = PROB_BITS'($urandom_range(0, PROB_TOP));
            for (int k = 0; k < stream_len; k++) begin
                case (profile)
                    0: begin
                        // noise: bits unrelated to the probability
                        p = PROB_BITS'($urandom_range(0, PROB_TOP));
                        if ($urandom_range(0, 31) == 0) p = '0;
                        b = 1'($urandom_range(0, 1));
                    end
                    1: begin
                        // skewed probabilities, bits drawn to match
                        p = $urandom_range(0, 1) ? PROB_BITS'($urandom_range(0, 255))
                                                 : PROB_BITS'(PROB_TOP - $urandom_range(0, 255));
                        b = ($urandom_range(0, PROB_TOP) >= p);
                    end
                    2: begin
                        p = fixed_p;
                        b = ($urandom_range(0, PROB_TOP) >= p);
                    end
                    default: begin
                        // mostly unlikely ones: long pending runs and carries
                        p = PROB_BITS'(PROB_TOP - $urandom_range(0, 15));
                        b = ($urandom_range(0, 7) != 0);
                    end
                endcase
                add_item(MODE_ENCODE, p, b, (made == 0) || ($urandom_range(0, 99) == 0));
                made++;
            end
            add_item(MODE_FLUSH, PROB_BITS'($urandom), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 9) == 0);
            made++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bit_items.size() != 0 || s_valid) @(posedge i_clk);
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
